### hdl/dtm_pkg.sv
`timescale 1ns / 1ps
// shared types, constants and the quarter-wave sine table for the tone mixer
// no dependencies; used by dds_tone_mixer_with_history

package dtm_pkg;

   // tone history ring, depth must be a power of two
   localparam int unsigned HIST_DEPTH = 16384;
   localparam int unsigned HIST_AW    = $clog2(HIST_DEPTH);

   // sine lookup: top SINE_BITS phase bits, two of them pick the quadrant
   localparam int unsigned SINE_BITS   = 10;
   localparam int unsigned QTR_BITS    = SINE_BITS - 2;
   localparam int unsigned QTR_ENTRIES = (1 << QTR_BITS) + 1;
   localparam logic [QTR_BITS:0] QTR_FULL = {1'b1, {QTR_BITS{1'b0}}};

   localparam int unsigned SAMPLE_W = 16;
   localparam int unsigned PTR_W    = 14;
   localparam int unsigned GAIN_W   = 15;
   localparam int unsigned MAG_W    = 15;

   localparam logic signed [SAMPLE_W-1:0] SAMPLE_MAX = {1'b0, {(SAMPLE_W-1){1'b1}}};
   localparam logic signed [SAMPLE_W-1:0] SAMPLE_MIN = {1'b1, {(SAMPLE_W-1){1'b0}}};

   localparam logic [31:0]       PHASE_INC_RESET = 32'd8947849;
   localparam logic [GAIN_W-1:0] TONE_GAIN_RESET = 15'd3277;

   // polynomial sine coefficients, Q15
   localparam longint unsigned POLY_A = 64'd51472;
   localparam longint unsigned POLY_B = 64'd21024;
   localparam longint unsigned POLY_C = 64'd2320;

   typedef enum logic {
      ACT_TICK = 1'b0,
      ACT_READ = 1'b1
   } action_type;

   typedef enum logic {
      CSR_PHASE_INC = 1'b0,
      CSR_TONE_GAIN = 1'b1
   } csr_index_type;

   typedef struct packed {
      action_type                  action;
      logic signed [SAMPLE_W-1:0]  playback_left;
      logic signed [SAMPLE_W-1:0]  playback_right;
      logic                        block_end;
      logic [PTR_W-1:0]            read_index;
   } req_type;

   typedef struct packed {
      logic signed [SAMPLE_W-1:0]  mix_left;
      logic signed [SAMPLE_W-1:0]  mix_right;
      logic signed [SAMPLE_W-1:0]  tone_sample;
      logic signed [SAMPLE_W-1:0]  history_value;
      logic [PTR_W-1:0]            committed_pointer;
   } rsp_type;

   typedef logic [MAG_W-1:0] sine_mag_type;
   typedef sine_mag_type sine_qtr_type [QTR_ENTRIES];

   // quarter-wave magnitude table, built at elaboration
   function automatic sine_qtr_type sine_qtr_build();
      sine_qtr_type    tbl;
      longint unsigned z;
      longint unsigned z2;
      longint unsigned t;
      longint unsigned v;
      longint unsigned y;
      longint unsigned mag;
      for (int r = 0; r < QTR_ENTRIES; r++) begin
         z   = longint'(r) << (15 - QTR_BITS);
         z2  = (z * z) >> 15;
         t   = (POLY_C * z2) >> 15;
         v   = ((POLY_B - t) * z2) >> 15;
         y   = (z * (POLY_A - v)) >> 15;
         mag = (y * 64'd32767 + 64'd16384) >> 15;
         if (mag > 64'd32767) begin
            mag = 64'd32767;
         end
         tbl[r] = mag[MAG_W-1:0];
      end
      return tbl;
   endfunction

   localparam sine_qtr_type SINE_QTR = sine_qtr_build();

endpackage

### hdl/dtm_ram.sv
`timescale 1ns / 1ps
// generic single-write, single-read RAM with registered read data
// read during a write to the same address returns the old contents

module dtm_ram #(
   parameter int unsigned WIDTH = 16,
   parameter int unsigned DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

### hdl/dds_tone_mixer_with_history.sv
`timescale 1ns / 1ps
// tone oscillator, playback mixer and tone history ring (top level)
// uses dtm_pkg and dtm_ram
//
//   port group   dir   handshake            payload
//   req_*        in    req_valid/req_stall  dtm_pkg::req_type
//   rsp_*        out   rsp_valid/rsp_stall  dtm_pkg::rsp_type
//   csr_*        in    csr_we               csr_index, csr_wdata
//
// one request per cycle while rsp_stall is low; results pass the s1, s2 and rsp registers
// stages: input register, sine quarter-table lookup, gain multiply and mix into the output register
// the history ring is one memory; a request reads it at the lookup stage and a tick writes it
// when it leaves the multiply stage, with a one-entry forward for the write in flight
// after reset no clearing pass: unwritten entries read as zero from the fill pointer and wrap flag
// each stage fills when it, or the stage after it, is empty or moving, so bubbles are squeezed out

module dds_tone_mixer_with_history (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  dtm_pkg::req_type       req_data,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output dtm_pkg::rsp_type       rsp_data,
   input  logic                   csr_we,
   input  dtm_pkg::csr_index_type csr_index,
   input  logic [31:0]            csr_wdata
);

   typedef struct packed {
      dtm_pkg::action_type                  action;
      logic signed [dtm_pkg::SAMPLE_W-1:0]  pl;
      logic signed [dtm_pkg::SAMPLE_W-1:0]  pr;
      logic [dtm_pkg::HIST_AW-1:0]          addr;
      logic                                 entry_ok;
      logic [dtm_pkg::HIST_AW-1:0]          commit;
      logic [dtm_pkg::SINE_BITS-1:0]        phase_idx;
   } stage1_type;

   typedef struct packed {
      dtm_pkg::action_type                  action;
      logic signed [dtm_pkg::SAMPLE_W-1:0]  pl;
      logic signed [dtm_pkg::SAMPLE_W-1:0]  pr;
      logic [dtm_pkg::HIST_AW-1:0]          addr;
      logic                                 entry_ok;
      logic [dtm_pkg::HIST_AW-1:0]          commit;
      logic [dtm_pkg::MAG_W-1:0]            mag;
      logic                                 neg;
   } stage2_type;

   function automatic logic signed [dtm_pkg::SAMPLE_W-1:0] sat_add(
      input logic signed [dtm_pkg::SAMPLE_W-1:0] a,
      input logic signed [dtm_pkg::SAMPLE_W-1:0] b
   );
      logic signed [dtm_pkg::SAMPLE_W:0] sum;
      sum = {a[dtm_pkg::SAMPLE_W-1], a} + {b[dtm_pkg::SAMPLE_W-1], b};
      if (sum[dtm_pkg::SAMPLE_W] != sum[dtm_pkg::SAMPLE_W-1]) begin
         return sum[dtm_pkg::SAMPLE_W] ? dtm_pkg::SAMPLE_MIN : dtm_pkg::SAMPLE_MAX;
      end
      return sum[dtm_pkg::SAMPLE_W-1:0];
   endfunction

   // configuration and running state
   logic [31:0]                     phase_inc_ff;
   logic [dtm_pkg::GAIN_W-1:0]      tone_gain_ff;
   logic [31:0]                     phase_ff;
   logic [31:0]                     phase_in;
   logic [dtm_pkg::HIST_AW-1:0]     wp_ff;
   logic [dtm_pkg::HIST_AW-1:0]     wp_in;
   logic [dtm_pkg::HIST_AW-1:0]     wp_step;
   logic [dtm_pkg::HIST_AW-1:0]     commit_ff;
   logic [dtm_pkg::HIST_AW-1:0]     commit_in;
   logic                            wrapped_ff;
   logic                            wrapped_in;

   // pipeline
   logic                            s1_valid_ff;
   logic                            s1_valid_in;
   stage1_type                      s1_ff;
   stage1_type                      s1_in;
   logic                            s2_valid_ff;
   logic                            s2_valid_in;
   stage2_type                      s2_ff;
   stage2_type                      s2_in;
   logic                            rsp_valid_ff;
   logic                            rsp_valid_in;
   dtm_pkg::rsp_type                rsp_ff;
   dtm_pkg::rsp_type                rsp_in;

   logic                            req_accept;
   logic                            req_is_tick;
   logic                            rsp_ready;
   logic                            s2_ready;
   logic                            s1_ready;
   logic                            s1_adv;
   logic                            s2_adv;

   logic [dtm_pkg::HIST_AW-1:0]     rd_idx;
   logic [1:0]                      quad;
   logic [dtm_pkg::QTR_BITS:0]      qidx;

   logic [2*dtm_pkg::MAG_W-1:0]     prod;
   logic [2*dtm_pkg::MAG_W:0]       rnd_sum;
   logic [dtm_pkg::MAG_W-1:0]       tmag;
   logic signed [dtm_pkg::SAMPLE_W-1:0] tone_abs;
   logic signed [dtm_pkg::SAMPLE_W-1:0] tone;
   logic signed [dtm_pkg::SAMPLE_W-1:0] hist_val;

   // history memory and write forward
   logic                            ram_we;
   logic                            ram_re;
   logic [dtm_pkg::SAMPLE_W-1:0]    ram_rd_data;
   logic                            fwd_hit_ff;
   logic                            fwd_hit_in;
   logic signed [dtm_pkg::SAMPLE_W-1:0] fwd_data_ff;
   logic signed [dtm_pkg::SAMPLE_W-1:0] fwd_data_in;

   // handshake and stage movement
   assign rsp_ready  = !rsp_valid_ff || !rsp_stall;
   assign s2_ready   = !s2_valid_ff || rsp_ready;
   assign s1_ready   = !s1_valid_ff || s2_ready;
   assign req_stall  = !s1_ready;
   assign req_accept = req_valid && !req_stall;
   assign s1_adv     = s1_valid_ff && s2_ready;
   assign s2_adv     = s2_valid_ff && rsp_ready;

   assign s1_valid_in  = req_accept || (s1_valid_ff && !s2_ready);
   assign s2_valid_in  = s1_adv || (s2_valid_ff && !rsp_ready);
   assign rsp_valid_in = s2_adv || (rsp_valid_ff && rsp_stall);

   // input stage: phase, write pointer and commit bookkeeping
   always_comb begin
      req_is_tick = (req_data.action == dtm_pkg::ACT_TICK);
      wp_step     = wp_ff + 1'b1;
      rd_idx      = req_data.read_index[dtm_pkg::HIST_AW-1:0];

      phase_in   = phase_ff;
      wp_in      = wp_ff;
      commit_in  = commit_ff;
      wrapped_in = wrapped_ff;
      if (req_accept && req_is_tick) begin
         phase_in = phase_ff + phase_inc_ff;
         wp_in    = wp_step;
         if (wp_ff == {dtm_pkg::HIST_AW{1'b1}}) begin
            wrapped_in = 1'b1;
         end
         if (req_data.block_end) begin
            commit_in = wp_step;
         end
      end

      s1_in.action    = req_data.action;
      s1_in.pl        = req_data.playback_left;
      s1_in.pr        = req_data.playback_right;
      s1_in.addr      = req_is_tick ? wp_ff : rd_idx;
      // entries at or past the fill pointer were never written before the first wrap
      s1_in.entry_ok  = wrapped_ff || (rd_idx < wp_ff);
      s1_in.commit    = commit_in;
      s1_in.phase_idx = phase_ff[31 -: dtm_pkg::SINE_BITS];
   end

   // lookup stage: quarter-wave table with mirroring
   always_comb begin
      quad = s1_ff.phase_idx[dtm_pkg::SINE_BITS-1 -: 2];
      qidx = {1'b0, s1_ff.phase_idx[dtm_pkg::QTR_BITS-1:0]};
      if (quad[0]) begin
         qidx = dtm_pkg::QTR_FULL - qidx;
      end

      s2_in.action   = s1_ff.action;
      s2_in.pl       = s1_ff.pl;
      s2_in.pr       = s1_ff.pr;
      s2_in.addr     = s1_ff.addr;
      s2_in.entry_ok = s1_ff.entry_ok;
      s2_in.commit   = s1_ff.commit;
      s2_in.mag      = dtm_pkg::SINE_QTR[qidx];
      s2_in.neg      = quad[1];
   end

   // multiply stage: gain with round half away from zero, then mix
   always_comb begin
      prod     = (2*dtm_pkg::MAG_W)'(s2_ff.mag) * (2*dtm_pkg::MAG_W)'(tone_gain_ff);
      rnd_sum  = {1'b0, prod} + (2*dtm_pkg::MAG_W+1)'(16384);
      tmag     = rnd_sum[2*dtm_pkg::MAG_W-1 -: dtm_pkg::MAG_W];
      tone_abs = {1'b0, tmag};
      tone     = s2_ff.neg ? -tone_abs : tone_abs;

      if (!s2_ff.entry_ok) begin
         hist_val = '0;
      end else if (fwd_hit_ff) begin
         hist_val = fwd_data_ff;
      end else begin
         hist_val = ram_rd_data;
      end

      rsp_in.committed_pointer = dtm_pkg::PTR_W'(s2_ff.commit);
      case (s2_ff.action)
         dtm_pkg::ACT_TICK: begin
            rsp_in.mix_left      = sat_add(tone, s2_ff.pl);
            rsp_in.mix_right     = sat_add(tone, s2_ff.pr);
            rsp_in.tone_sample   = tone;
            rsp_in.history_value = '0;
         end
         default: begin
            rsp_in.mix_left      = '0;
            rsp_in.mix_right     = '0;
            rsp_in.tone_sample   = '0;
            rsp_in.history_value = hist_val;
         end
      endcase
   end

   // ring access: reads leave the lookup stage, writes leave the multiply stage
   assign ram_we = s2_adv && (s2_ff.action == dtm_pkg::ACT_TICK);
   assign ram_re = s1_adv && (s1_ff.action == dtm_pkg::ACT_READ);

   // a tick writing on the same edge as the read is not yet visible in the ram
   always_comb begin
      fwd_hit_in  = fwd_hit_ff;
      fwd_data_in = fwd_data_ff;
      if (ram_re) begin
         fwd_hit_in  = ram_we && (s2_ff.addr == s1_ff.addr);
         fwd_data_in = tone;
      end
   end

   dtm_ram #(
      .WIDTH (dtm_pkg::SAMPLE_W),
      .DEPTH (dtm_pkg::HIST_DEPTH)
   ) u_history (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (s2_ff.addr),
      .wr_data (tone),
      .rd_en   (ram_re),
      .rd_addr (s1_ff.addr),
      .rd_data (ram_rd_data)
   );

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_inc_ff <= dtm_pkg::PHASE_INC_RESET;
         tone_gain_ff <= dtm_pkg::TONE_GAIN_RESET;
         phase_ff     <= '0;
         wp_ff        <= '0;
         commit_ff    <= '0;
         wrapped_ff   <= 1'b0;
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         fwd_hit_ff   <= 1'b0;
      end else begin
         phase_ff     <= phase_in;
         wp_ff        <= wp_in;
         commit_ff    <= commit_in;
         wrapped_ff   <= wrapped_in;
         s1_valid_ff  <= s1_valid_in;
         s2_valid_ff  <= s2_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         fwd_hit_ff   <= fwd_hit_in;
         if (csr_we) begin
            unique case (csr_index)
               dtm_pkg::CSR_PHASE_INC: begin
                  phase_inc_ff <= csr_wdata;
               end
               dtm_pkg::CSR_TONE_GAIN: begin
                  tone_gain_ff <= csr_wdata[dtm_pkg::GAIN_W-1:0];
               end
            endcase
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      fwd_data_ff <= fwd_data_in;
      if (req_accept) begin
         s1_ff <= s1_in;
      end
      if (s1_adv) begin
         s2_ff <= s2_in;
      end
      if (s2_adv) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   // before the first wrap the committed pointer never runs ahead of the fill pointer
   a_commit_behind: assert property (@(posedge clock) disable iff (reset)
      !wrapped_ff |-> (commit_ff <= wp_ff))
      else $error("commit pointer ahead of write pointer before wrap");

   a_wp_step: assert property (@(posedge clock) disable iff (reset)
      (req_accept && req_data.action == dtm_pkg::ACT_TICK) |=> (wp_ff == $past(wp_ff) + 1'b1))
      else $error("write pointer did not advance on an accepted tick");

   a_full_stalls: assert property (@(posedge clock) disable iff (reset)
      (s1_valid_ff && s2_valid_ff && rsp_valid_ff && rsp_stall) |-> req_stall)
      else $error("request taken while pipeline is full and blocked");

   a_read_fields: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_ff.history_value != '0) |->
         (rsp_ff.tone_sample == '0 && rsp_ff.mix_left == '0 && rsp_ff.mix_right == '0))
      else $error("history value reported alongside a tone result");

endmodule
